// ===== sv/sxbf_pkg.sv =====
// sxbf_pkg: types and fixed constants of the sx bus frame interface
// no dependencies; imported by sx_bus_frame_interface_core

package sxbf_pkg;

    // mirror geometry
    localparam int unsigned ADDRESSES       = 112;
    localparam int unsigned ADDR_W          = $clog2(ADDRESSES);
    localparam int unsigned BYTES_PER_FRAME = 7;
    localparam int unsigned ENTRY_W         = 9;

    // frame layout
    localparam int unsigned UNIT_BITS    = 12;
    localparam int unsigned SEP_LEN      = 3;
    localparam int unsigned ZEROS_NEEDED = 3;

    // stream widths
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    // receive phase of the frame decoder
    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_PWR  = 2'd1,
        PH_ADDR = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_CLK   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_POWER = 2'd3
    } req_t;

    // drive codes for the next bit slot
    localparam logic [1:0] DRV_LOW      = 2'd0;
    localparam logic [1:0] DRV_HIGH     = 2'd1;
    localparam logic [1:0] DRV_RELEASED = 2'd2;

    // power request register value when nothing is queued
    localparam logic [1:0] POWER_NONE = 2'd2;

endpackage

// ===== sv/sxbf_ram.sv =====
// sxbf_ram: generic synchronous ram, one write port and two registered read ports
// no dependencies

module sxbf_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 112
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== sv/sx_bus_frame_interface_core.sv =====
// sx_bus_frame_interface_core: sx bus frame decoder, transmitter and 112-byte mirror
// depends on sxbf_pkg and sxbf_ram
//
// Each transfer on the input stream is one bus clock edge (with the sampled data
// bit), a host read, a host write or a power request, and gives exactly one
// result transfer. The mirror of the 112 bus addresses sits in a RAM with one
// write port and two registered read ports; a per-entry valid flag makes
// entries read as zero until written, so no clearing pass is needed after
// reset. An item is read from the mirror in the cycle it is accepted and
// completed (state update, write back, result) in the next. At the end of a
// data unit whose following byte is pending a second mirror write is needed
// to clear that pending flag, which holds off the next item because the RAM
// has a single write port. The result register is freed at the edge its
// transfer completes, so the next item can be accepted at that same edge; a
// result that is not taken holds the input.

module sx_bus_frame_interface_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // bus_bit[0], address[8:1], write_data[16:9], power_value[17], zero fill
    input  logic [sxbf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // drive[1:0], read_data[9:2], write_pending[10], status[11],
    // bus_power[12], frame_zero[13], zero fill
    output logic [sxbf_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    import sxbf_pkg::*;

    localparam logic [ADDR_W:0] ADDR_LIMIT = (ADDR_W+1)'(ADDRESSES);

    // host address to mirror slot: (15 - a%16)*7 + 6 - a/16
    function automatic logic [ADDR_W-1:0] host_slot(input logic [7:0] a);
        logic [ADDR_W-1:0] row;
        row = {3'b000, ~a[3:0]};
        return (row << 3) - row + ADDR_W'(6) - {4'b0000, a[6:4]};
    endfunction

    // first slot of a frame: frame_number * 7
    function automatic logic [ADDR_W-1:0] frame_slot(input logic [3:0] fn);
        return {fn, 3'b000} - {3'b000, fn};
    endfunction

    // ------------------------------------------------------------------
    // decoder state
    phase_t                  phase_reg, phase_next;
    logic [1:0]              zero_count_reg, zero_count_next;
    logic [1:0]              sep_count_reg, sep_count_next;
    logic [3:0]              bit_count_reg, bit_count_next;
    logic [3:0]              frame_number_reg, frame_number_next;
    logic [ADDR_W-1:0]       slot_index_reg, slot_index_next;
    logic [2:0]              bytes_left_reg, bytes_left_next;
    logic [7:0]              rx_shift_reg, rx_shift_next;
    logic [7:0]              tx_shift_reg, tx_shift_next;
    logic                    tx_active_reg, tx_active_next;
    logic [1:0]              power_request_reg, power_request_next;
    logic                    power_seen_reg, power_seen_next;

    // completion stage
    logic                    s2_valid_reg;
    req_t                    s2_req_reg;
    logic                    s2_bit_reg;
    logic [7:0]              s2_addr_reg;
    logic [7:0]              s2_wdata_reg;
    logic                    s2_pwr_reg;
    logic [ADDR_W-1:0]       s2_slot_a_reg;
    logic [ADDR_W-1:0]       s2_slot_b_reg;

    // deferred pending-clear write
    logic                    defer_valid_reg, defer_valid_next;
    logic [ADDR_W-1:0]       defer_addr_reg, defer_addr_next;
    logic [7:0]              defer_data_reg, defer_data_next;

    // result register
    logic                    m_valid_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    // mirror valid flags
    logic [ADDRESSES-1:0]    valid_reg;

    // input fields
    req_t                    in_req;
    logic                    in_bit;
    logic [7:0]              in_addr;
    logic [7:0]              in_wdata;
    logic                    in_pwr;
    logic                    accept;

    // mirror ports
    logic [ADDR_W-1:0]       rd_slot_a;
    logic [ADDR_W-1:0]       rd_slot_b;
    logic [ENTRY_W-1:0]      rdata_a;
    logic [ENTRY_W-1:0]      rdata_b;
    logic                    s2_we;
    logic [ADDR_W-1:0]       s2_waddr;
    logic [ENTRY_W-1:0]      s2_wdata;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;

    // result fields
    logic [1:0]              res_drive;
    logic [7:0]              res_read_data;
    logic                    res_pending;
    logic                    res_status;
    logic                    res_frame_zero;

    // ------------------------------------------------------------------
    // input unpacking and handshake
    assign in_req   = req_t'(s_axis_tuser);
    assign in_bit   = s_axis_tdata[0];
    assign in_addr  = s_axis_tdata[8:1];
    assign in_wdata = s_axis_tdata[16:9];
    assign in_pwr   = s_axis_tdata[17];

    assign s_axis_tready = !s2_valid_reg && !defer_valid_reg
                           && (!m_valid_reg || m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;

    // mirror read addresses for the item being accepted
    always_comb
    begin
        logic [3:0] fn_pred;
        fn_pred = (sep_count_reg != 2'd1) ? {frame_number_reg[2:0], in_bit}
                                          : frame_number_reg;
        if (in_req != REQ_CLK)
        begin
            rd_slot_a = host_slot(in_addr);
        end
        else if (phase_reg == PH_ADDR)
        begin
            rd_slot_a = frame_slot(fn_pred);
        end
        else
        begin
            rd_slot_a = slot_index_reg;
        end
        rd_slot_b = slot_index_reg + ADDR_W'(1);
    end

    // mirror memory
    assign ram_we    = s2_we || defer_valid_reg;
    assign ram_waddr = defer_valid_reg ? defer_addr_reg : s2_waddr;
    assign ram_wdata = defer_valid_reg ? {1'b0, defer_data_reg} : s2_wdata;

    sxbf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ADDRESSES)
    ) u_mirror (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (rd_slot_a),
        .rdata_a (rdata_a),
        .raddr_b (rd_slot_b),
        .rdata_b (rdata_b)
    );

    // ------------------------------------------------------------------
    // completion: frame decoder, transmitter and host access
    always_comb
    begin
        logic [ENTRY_W-1:0] ea;
        logic [ENTRY_W-1:0] eb;
        logic [1:0]         sep_dec;
        logic [3:0]         bc_dec;
        logic [3:0]         fn_shift;
        logic [2:0]         bl_dec;
        logic [ADDR_W-1:0]  slot_inc;
        logic [ADDR_W-1:0]  load_slot;
        logic               tx_act_w;
        logic [7:0]         txs_w;

        ea = ({1'b0, s2_slot_a_reg} < ADDR_LIMIT && valid_reg[s2_slot_a_reg])
             ? rdata_a : '0;
        eb = ({1'b0, s2_slot_b_reg} < ADDR_LIMIT && valid_reg[s2_slot_b_reg])
             ? rdata_b : '0;
        sep_dec   = sep_count_reg - 2'd1;
        bc_dec    = bit_count_reg - 4'd1;
        fn_shift  = {frame_number_reg[2:0], s2_bit_reg};
        bl_dec    = bytes_left_reg - 3'd1;
        slot_inc  = slot_index_reg + ADDR_W'(1);
        load_slot = frame_slot(frame_number_reg);
        tx_act_w  = tx_active_reg;
        txs_w     = tx_shift_reg;

        phase_next         = phase_reg;
        zero_count_next    = zero_count_reg;
        sep_count_next     = sep_count_reg;
        bit_count_next     = bit_count_reg;
        frame_number_next  = frame_number_reg;
        slot_index_next    = slot_index_reg;
        bytes_left_next    = bytes_left_reg;
        rx_shift_next      = rx_shift_reg;
        tx_shift_next      = tx_shift_reg;
        tx_active_next     = tx_active_reg;
        power_request_next = power_request_reg;
        power_seen_next    = power_seen_reg;
        defer_valid_next   = 1'b0;
        defer_addr_next    = defer_addr_reg;
        defer_data_next    = defer_data_reg;

        s2_we          = 1'b0;
        s2_waddr       = s2_slot_a_reg;
        s2_wdata       = '0;
        res_drive      = DRV_RELEASED;
        res_read_data  = 8'h00;
        res_pending    = 1'b0;
        res_status     = 1'b0;
        res_frame_zero = 1'b0;

        if (s2_valid_reg)
        begin
            unique case (s2_req_reg)
                REQ_CLK:
                begin
                    unique case (phase_reg)
                        PH_SYNC:
                        begin
                            if (!s2_bit_reg)
                            begin
                                if (zero_count_reg != 2'd0)
                                begin
                                    zero_count_next = zero_count_reg - 2'd1;
                                end
                            end
                            else if (zero_count_reg == 2'd0)
                            begin
                                phase_next     = PH_PWR;
                                sep_count_next = 2'(SEP_LEN - 1);
                                if (power_request_reg != POWER_NONE)
                                begin
                                    res_drive          = power_request_reg;
                                    power_request_next = POWER_NONE;
                                end
                            end
                            else
                            begin
                                zero_count_next = 2'(ZEROS_NEEDED);
                            end
                        end
                        PH_PWR:
                        begin
                            if (sep_dec == 2'd0)
                            begin
                                phase_next        = PH_ADDR;
                                bit_count_next    = 4'(UNIT_BITS / 2);
                                sep_count_next    = 2'(SEP_LEN);
                                frame_number_next = 4'd0;
                            end
                            else
                            begin
                                sep_count_next  = sep_dec;
                                power_seen_next = s2_bit_reg;
                            end
                        end
                        PH_ADDR:
                        begin
                            if (sep_dec == 2'd0)
                            begin
                                sep_count_next = 2'(SEP_LEN);
                            end
                            else
                            begin
                                sep_count_next    = sep_dec;
                                frame_number_next = fn_shift;
                                if (bit_count_reg == 4'd2 && fn_shift == 4'd0)
                                begin
                                    res_frame_zero = 1'b1;
                                end
                            end
                            bit_count_next = bc_dec;
                            if (bc_dec == 4'd0)
                            begin
                                load_slot       = frame_slot(frame_number_next);
                                slot_index_next = load_slot;
                                phase_next      = PH_DATA;
                                bit_count_next  = 4'(UNIT_BITS);
                                tx_active_next  = ea[8];
                                // first byte of the frame goes out if pending
                                if (ea[8])
                                begin
                                    s2_we         = 1'b1;
                                    s2_waddr      = load_slot;
                                    s2_wdata      = {1'b0, ea[7:0]};
                                    res_drive     = {1'b0, ea[0]};
                                    tx_shift_next = {1'b0, ea[7:1]};
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            sep_count_next = (sep_dec == 2'd0) ? 2'(SEP_LEN) : sep_dec;
                            if (sep_dec != 2'd0)
                            begin
                                rx_shift_next = {s2_bit_reg, rx_shift_reg[7:1]};
                            end
                            bit_count_next = bc_dec;
                            if (bc_dec == 4'd0)
                            begin
                                // store the received byte unless a host write waits
                                if ({1'b0, slot_index_reg} < ADDR_LIMIT && !ea[8])
                                begin
                                    s2_we    = 1'b1;
                                    s2_waddr = slot_index_reg;
                                    s2_wdata = {1'b0, rx_shift_next};
                                end
                                bit_count_next  = 4'(UNIT_BITS);
                                slot_index_next = slot_inc;
                                bytes_left_next = bl_dec;
                                tx_act_w        = 1'b0;
                                if (bl_dec == 3'd0)
                                begin
                                    bytes_left_next = 3'(BYTES_PER_FRAME);
                                    phase_next      = PH_SYNC;
                                    zero_count_next = 2'(ZEROS_NEEDED);
                                end
                                else if ({1'b0, slot_inc} < ADDR_LIMIT && eb[8])
                                begin
                                    // next byte pending: take it, clear flag next cycle
                                    tx_act_w         = 1'b1;
                                    txs_w            = eb[7:0];
                                    defer_valid_next = 1'b1;
                                    defer_addr_next  = slot_inc;
                                    defer_data_next  = eb[7:0];
                                end
                            end
                            if (!(bc_dec == 4'd0 && bl_dec == 3'd0)
                                && sep_count_next != 2'd1 && tx_act_w)
                            begin
                                res_drive = {1'b0, txs_w[0]};
                                txs_w     = {1'b0, txs_w[7:1]};
                            end
                            tx_active_next = tx_act_w;
                            tx_shift_next  = txs_w;
                        end
                        default:
                        begin
                            phase_next = PH_SYNC;
                        end
                    endcase
                end
                REQ_POWER:
                begin
                    power_request_next = {1'b0, s2_pwr_reg};
                end
                REQ_READ, REQ_WRITE:
                begin
                    if ({1'b0, s2_addr_reg} >= {1'b0, ADDR_LIMIT})
                    begin
                        res_status = 1'b1;
                    end
                    else if (s2_req_reg == REQ_WRITE)
                    begin
                        s2_we         = 1'b1;
                        s2_waddr      = s2_slot_a_reg;
                        s2_wdata      = {1'b1, s2_wdata_reg};
                        res_read_data = s2_wdata_reg;
                        res_pending   = 1'b1;
                    end
                    else
                    begin
                        res_read_data = ea[7:0];
                        res_pending   = ea[8];
                    end
                end
                default:
                begin
                    res_status = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SYNC;
            zero_count_reg    <= 2'(ZEROS_NEEDED);
            sep_count_reg     <= 2'(SEP_LEN);
            bit_count_reg     <= 4'd3;
            frame_number_reg  <= 4'd0;
            slot_index_reg    <= '0;
            bytes_left_reg    <= 3'(BYTES_PER_FRAME);
            rx_shift_reg      <= 8'h00;
            tx_shift_reg      <= 8'h00;
            tx_active_reg     <= 1'b0;
            power_request_reg <= POWER_NONE;
            power_seen_reg    <= 1'b0;
            defer_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            zero_count_reg    <= zero_count_next;
            sep_count_reg     <= sep_count_next;
            bit_count_reg     <= bit_count_next;
            frame_number_reg  <= frame_number_next;
            slot_index_reg    <= slot_index_next;
            bytes_left_reg    <= bytes_left_next;
            rx_shift_reg      <= rx_shift_next;
            tx_shift_reg      <= tx_shift_next;
            tx_active_reg     <= tx_active_next;
            power_request_reg <= power_request_next;
            power_seen_reg    <= power_seen_next;
            defer_valid_reg   <= defer_valid_next;
        end
    end

    // deferred write payload
    always_ff @(posedge clk)
    begin
        defer_addr_reg <= defer_addr_next;
        defer_data_reg <= defer_data_next;
    end

    // mirror valid flags, set by any write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[ram_waddr] <= 1'b1;
        end
    end

    // completion stage capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_req_reg    <= in_req;
            s2_bit_reg    <= in_bit;
            s2_addr_reg   <= in_addr;
            s2_wdata_reg  <= in_wdata;
            s2_pwr_reg    <= in_pwr;
            s2_slot_a_reg <= rd_slot_a;
            s2_slot_b_reg <= rd_slot_b;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s2_valid_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            m_data_reg <= {2'b00, res_frame_zero, power_seen_next, res_status,
                           res_pending, res_read_data, res_drive};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // checks
    a_defer_after_stage: assert property (@(posedge clk) disable iff (!rst_n)
        defer_valid_reg |-> $past(s2_valid_reg))
        else $error("deferred mirror write without a completing item");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg || defer_valid_reg) |-> !s_axis_tready)
        else $error("item accepted while mirror access in flight");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |=> m_axis_tvalid)
        else $error("completed item did not produce a result transfer");

    a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (!m_valid_reg || $past(m_axis_tready)))
        else $error("result register overwritten before transfer");

    a_power_code: assert property (@(posedge clk) disable iff (!rst_n)
        power_request_reg != 2'd3)
        else $error("power request register holds an unused code");

endmodule

// ===== sim/sx_bus_frame_interface_core_test.sv =====
// testbench for sx_bus_frame_interface_core: directed table, then random sx bus frames
// mixed with host reads, writes, power requests; each result checked against table or predictor
// depends on sxbf_pkg and the core with its mirror ram
`timescale 1ns / 100ps

module sx_bus_frame_interface_core_test;

    import sxbf_pkg::*;

    // one result transfer, laid out as in m_axis_tdata from the highest bit down
    typedef struct packed {
        logic       fz;
        logic       bp;
        logic       st;
        logic       wp;
        logic [7:0] rd;
        logic [1:0] drive;
    } sx_res_t;

    // one row of the directed table
    typedef struct {
        req_t       rq;
        logic       b;
        logic [7:0] a;
        logic [7:0] d;
        logic       p;
        bit         typed;
        sx_res_t    want;
    } stim_row_t;

    localparam int DIR_ROWS = 22;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = REQ_CLK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // predicted copy of the block state; mirror bit 8 marks a byte waiting for its bus slot
    logic [8:0] mirror_m [0:ADDRESSES-1];
    phase_t     rx_ph;
    logic [1:0] zeros_left;
    logic [1:0] sep_left;
    logic [1:0] power_req;
    logic [3:0] unit_left;
    logic [3:0] frame_num;
    logic [6:0] slot_at;
    logic [2:0] bytes_todo;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
    logic       tx_busy;
    logic       power_bus;

    sx_res_t    sx_results_due [$];
    stim_row_t  dir_rows [DIR_ROWS];
    int         mismatches = 0;
    int         items_sent = 0;
    bit         steady_run = 1'b0;
    logic [1:0] bus_drive = DRV_RELEASED;
    sx_res_t    got_res;
    sx_res_t    want_res;

    sx_bus_frame_interface_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // hard stop well beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // start sending the byte of the current slot if it has a write waiting
    function automatic void take_pending();
        tx_busy = 1'b0;
        if (slot_at < ADDRESSES && mirror_m[slot_at][8])
        begin
            tx_byte = mirror_m[slot_at][7:0];
            mirror_m[slot_at][8] = 1'b0;
            tx_busy = 1'b1;
        end
    endfunction

    // frame decoder and transmitter for one bus clock edge; returns the next slot drive
    function automatic logic [1:0] bus_edge(input logic b, output logic fz);
        logic [1:0] drv;
        logic       frame_done;
        drv = DRV_RELEASED;
        fz = 1'b0;
        frame_done = 1'b0;
        case (rx_ph)
            PH_SYNC:
            begin
                if (!b)
                begin
                    if (zeros_left != 0) zeros_left = zeros_left - 1'b1;
                end
                else if (zeros_left == 0)
                begin
                    rx_ph = PH_PWR;
                    sep_left = 2'(SEP_LEN - 1);
                    if (power_req != POWER_NONE)
                    begin
                        drv = power_req;
                        power_req = POWER_NONE;
                    end
                end
                else
                begin
                    // a one before enough zeros restarts the sync search
                    zeros_left = 2'(ZEROS_NEEDED);
                end
            end
            PH_PWR:
            begin
                sep_left = sep_left - 1'b1;
                if (sep_left == 0)
                begin
                    rx_ph = PH_ADDR;
                    unit_left = 4'(UNIT_BITS / 2);
                    sep_left = 2'(SEP_LEN);
                    frame_num = '0;
                end
                else
                begin
                    power_bus = b;
                end
            end
            PH_ADDR:
            begin
                sep_left = sep_left - 1'b1;
                if (sep_left == 0)
                begin
                    sep_left = 2'(SEP_LEN);
                end
                else
                begin
                    frame_num = {frame_num[2:0], b};
                    if (unit_left == 2 && frame_num == 0) fz = 1'b1;
                end
                unit_left = unit_left - 1'b1;
                if (unit_left == 0)
                begin
                    slot_at = 7'(frame_num * BYTES_PER_FRAME);
                    rx_ph = PH_DATA;
                    unit_left = 4'(UNIT_BITS);
                    take_pending();
                    if (tx_busy)
                    begin
                        drv = tx_byte[0] ? DRV_HIGH : DRV_LOW;
                        tx_byte = tx_byte >> 1;
                    end
                end
            end
            default:
            begin
                sep_left = sep_left - 1'b1;
                if (sep_left == 0) sep_left = 2'(SEP_LEN);
                else rx_byte = {b, rx_byte[7:1]};
                unit_left = unit_left - 1'b1;
                if (unit_left == 0)
                begin
                    // a slot with a write waiting keeps the host byte
                    if (slot_at < ADDRESSES && !mirror_m[slot_at][8])
                        mirror_m[slot_at] = {1'b0, rx_byte};
                    unit_left = 4'(UNIT_BITS);
                    slot_at = slot_at + 1'b1;
                    bytes_todo = bytes_todo - 1'b1;
                    if (bytes_todo == 0)
                    begin
                        bytes_todo = 3'(BYTES_PER_FRAME);
                        rx_ph = PH_SYNC;
                        zeros_left = 2'(ZEROS_NEEDED);
                        tx_busy = 1'b0;
                        frame_done = 1'b1;
                    end
                    else
                    begin
                        take_pending();
                    end
                end
                // next slot is a separator when one bit of the group is left
                if (!frame_done && sep_left != 1 && tx_busy)
                begin
                    drv = tx_byte[0] ? DRV_HIGH : DRV_LOW;
                    tx_byte = tx_byte >> 1;
                end
            end
        endcase
        return drv;
    endfunction

    // expected result of one accepted item, updating the predicted state
    function automatic sx_res_t sx_step(input req_t rq, input logic b, input logic [7:0] a,
                                        input logic [7:0] d, input logic p);
        sx_res_t r;
        logic    fz_v;
        int      hs;
        r = '0;
        r.drive = DRV_RELEASED;
        case (rq)
            REQ_CLK:
            begin
                r.drive = bus_edge(b, fz_v);
                r.fz = fz_v;
            end
            REQ_POWER:
            begin
                power_req = {1'b0, p};
            end
            default:
            begin
                if (a >= ADDRESSES)
                begin
                    r.st = 1'b1;
                end
                else
                begin
                    hs = (15 - int'(a[3:0])) * BYTES_PER_FRAME + 6 - int'(a[7:4]);
                    if (rq == REQ_WRITE) mirror_m[hs] = {1'b1, d};
                    r.rd = mirror_m[hs][7:0];
                    r.wp = mirror_m[hs][8];
                end
            end
        endcase
        r.bp = power_bus;
        return r;
    endfunction

    function automatic sx_res_t mk_res(logic [1:0] drv, logic [7:0] rd, logic wp, logic st,
                                       logic bp, logic fz);
        sx_res_t r;
        r.drive = drv;
        r.rd = rd;
        r.wp = wp;
        r.st = st;
        r.bp = bp;
        r.fz = fz;
        return r;
    endfunction

    function automatic stim_row_t row(req_t rq, logic b, logic [7:0] a, logic [7:0] d,
                                      logic p, bit typed, sx_res_t want);
        stim_row_t s;
        s.rq = rq;
        s.b = b;
        s.a = a;
        s.d = d;
        s.p = p;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    // one input transfer with random idle cycles ahead of it; predicts once accepted
    task automatic send_item(input req_t rq, input logic b, input logic [7:0] a,
                             input logic [7:0] d, input logic p, input bit typed,
                             input sx_res_t want);
        sx_res_t r;
        steady_run = (items_sent >= 300 && items_sent < 520);
        while (!steady_run && $urandom_range(99) < 18)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({p, d, a, b});
        s_axis_tuser  <= rq;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        r = sx_step(rq, b, a, d, p);
        if (rq == REQ_CLK) bus_drive = r.drive;
        sx_results_due.push_back(typed ? want : r);
        items_sent++;
    endtask

    // random host read, write or power request; some addresses out of range
    task automatic send_host();
        logic [7:0] a;
        int         k;
        k = $urandom_range(99);
        if ($urandom_range(99) < 85) a = 8'($urandom_range(ADDRESSES - 1));
        else a = 8'($urandom_range(255, ADDRESSES));
        if (k < 40)
            send_item(REQ_READ, 1'($urandom_range(1)), a, 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'b0, '0);
        else if (k < 80)
            send_item(REQ_WRITE, 1'($urandom_range(1)), a, 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'b0, '0);
        else
            send_item(REQ_POWER, 1'($urandom_range(1)), a, 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'b0, '0);
    endtask

    // one well-formed 96-bit frame with random content, sometimes cut short
    task automatic send_frame();
        logic [3:0] fn;
        logic [7:0] byte_v;
        logic       bv;
        bit         fb [$];
        int         slot;
        int         n_wr;
        int         len;
        fn = 4'($urandom_range(15));
        // queue host writes into this frame's slots so they go out on the bus
        n_wr = ($urandom_range(1) == 1) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n_wr; i++)
        begin
            slot = fn * BYTES_PER_FRAME + $urandom_range(BYTES_PER_FRAME - 1);
            send_item(REQ_WRITE, 1'($urandom_range(1)),
                      8'((6 - slot % BYTES_PER_FRAME) * 16 + 15 - slot / BYTES_PER_FRAME),
                      8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
        end
        if ($urandom_range(99) < 25)
            send_item(REQ_POWER, 1'($urandom_range(1)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
        // header: sync, power bit, frame number, separators
        fb = '{1'b0, 1'b0, 1'b0, 1'b1, 1'($urandom_range(1)), 1'b1,
               fn[3], fn[2], 1'b1, fn[1], fn[0], 1'b1};
        for (int k = 0; k < BYTES_PER_FRAME; k++)
        begin
            byte_v = 8'($urandom_range(255));
            fb.push_back(byte_v[0]);
            fb.push_back(byte_v[1]);
            fb.push_back(1'b1);
            fb.push_back(byte_v[2]);
            fb.push_back(byte_v[3]);
            fb.push_back(1'b1);
            fb.push_back(byte_v[4]);
            fb.push_back(byte_v[5]);
            fb.push_back(1'b1);
            fb.push_back(byte_v[6]);
            fb.push_back(byte_v[7]);
            fb.push_back(1'b1);
        end
        len = ($urandom_range(99) < 8) ? $urandom_range(4, 95) : fb.size();
        for (int i = 0; i < len; i++)
        begin
            // a driven slot mostly reads back what the block drove
            bv = fb[i];
            if (bus_drive != DRV_RELEASED && $urandom_range(99) < 85) bv = bus_drive[0];
            send_item(REQ_CLK, bv, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'b0, '0);
            if ($urandom_range(99) < 5) send_host();
        end
    endtask

    // hold the input side until every expected result has come
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sx_results_due.size() != 0) @(posedge clk);
    endtask

    // result side stalls at random, except during the steady stretch
    always @(posedge clk)
    begin
        m_axis_tready <= steady_run || ($urandom_range(99) >= 18);
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = sx_res_t'(m_axis_tdata[$bits(sx_res_t)-1:0]);
            if (sx_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: got %h", got_res);
            end
            else
            begin
                want_res = sx_results_due.pop_front();
                if (got_res.drive !== want_res.drive || got_res.rd !== want_res.rd ||
                    got_res.wp !== want_res.wp || got_res.st !== want_res.st ||
                    got_res.bp !== want_res.bp || got_res.fz !== want_res.fz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: drive %0d/%0d rd %h/%h wp %b/%b st %b/%b bp %b/%b fz %b/%b (exp/got)",
                                 want_res.drive, got_res.drive, want_res.rd, got_res.rd,
                                 want_res.wp, got_res.wp, want_res.st, got_res.st,
                                 want_res.bp, got_res.bp, want_res.fz, got_res.fz);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        bit paused;
        int pick;
        int n;
        paused = 1'b0;

        // predictor reset state
        foreach (mirror_m[i]) mirror_m[i] = '0;
        rx_ph      = PH_SYNC;
        zeros_left = 2'(ZEROS_NEEDED);
        sep_left   = 2'(SEP_LEN);
        unit_left  = 4'd3;
        frame_num  = '0;
        slot_at    = '0;
        bytes_todo = 3'(BYTES_PER_FRAME);
        rx_byte    = '0;
        tx_byte    = '0;
        tx_busy    = 1'b0;
        power_req  = POWER_NONE;
        power_bus  = 1'b0;

        dir_rows = '{
            // after reset, range limits of the host address
            row(REQ_READ,  1'b0, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_READ,  1'b1, 8'd255, 8'hFF, 1'b1, 1, mk_res(DRV_RELEASED, 8'h00, 0, 1, 0, 0)),
            row(REQ_READ,  1'b0, 8'd112, 8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 1, 0, 0)),
            row(REQ_READ,  1'b0, 8'd127, 8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 1, 0, 0)),
            // writes, then a second write over a byte still waiting
            row(REQ_WRITE, 1'b0, 8'd111, 8'hFF, 1'b0, 1, mk_res(DRV_RELEASED, 8'hFF, 1, 0, 0, 0)),
            row(REQ_WRITE, 1'b1, 8'd111, 8'h00, 1'b1, 1, mk_res(DRV_RELEASED, 8'h00, 1, 0, 0, 0)),
            row(REQ_READ,  1'b0, 8'd111, 8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 1, 0, 0, 0)),
            row(REQ_WRITE, 1'b0, 8'd0,   8'hA5, 1'b0, 1, mk_res(DRV_RELEASED, 8'hA5, 1, 0, 0, 0)),
            row(REQ_WRITE, 1'b0, 8'd200, 8'h5A, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 1, 0, 0)),
            row(REQ_WRITE, 1'b0, 8'd16,  8'h5A, 1'b0, 1, mk_res(DRV_RELEASED, 8'h5A, 1, 0, 0, 0)),
            // power requests, the later one wins
            row(REQ_POWER, 1'b0, 8'd0,   8'h00, 1'b1, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_POWER, 1'b0, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            // sync search broken by an early one, then enough zeros
            row(REQ_CLK,   1'b0, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_CLK,   1'b0, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_CLK,   1'b1, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_CLK,   1'b0, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_CLK,   1'b0, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_CLK,   1'b0, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_CLK,   1'b0, 8'd0,   8'h00, 1'b0, 1, mk_res(DRV_RELEASED, 8'h00, 0, 0, 0, 0)),
            row(REQ_WRITE, 1'b0, 8'h55,  8'h3C, 1'b0, 0, '0),
            row(REQ_READ,  1'b0, 8'h2A,  8'h00, 1'b0, 0, '0),
            row(REQ_POWER, 1'b0, 8'h00,  8'h00, 1'b1, 0, '0)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
            send_item(dir_rows[i].rq, dir_rows[i].b, dir_rows[i].a, dir_rows[i].d,
                      dir_rows[i].p, dir_rows[i].typed, dir_rows[i].want);

        // random part: mostly frames, some line noise and host bursts
        while (items_sent < 1450)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                send_frame();
            end
            else if (pick < 80)
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    send_item(REQ_CLK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_host();
            end
            if (!paused && items_sent > 700)
            begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && sx_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
